// ----- rtl/sc2a_pkg.sv -----
// Package for the set-1 scancode translator: key codes and US layout tables.
// No dependencies; imported by scancode_to_ascii_with_modifiers.
package sc2a_pkg;

  typedef logic [7:0] scancode_t;
  typedef logic [6:0] ascii_t;
  typedef logic [5:0] key_idx_t;

  // Make codes of interest
  localparam scancode_t SC_NULL      = 8'h00;
  localparam scancode_t SC_BACKSPACE = 8'h0E;
  localparam scancode_t SC_ENTER     = 8'h1C;
  localparam scancode_t SC_CTRL      = 8'h1D;
  localparam scancode_t SC_L         = 8'h26;
  localparam scancode_t SC_LSHIFT    = 8'h2A;
  localparam scancode_t SC_RSHIFT    = 8'h36;
  localparam scancode_t SC_CAPS      = 8'h3A;
  localparam scancode_t SC_MAKE_LAST = 8'h3A;
  // Release codes (make code with bit 7 set)
  localparam scancode_t SC_BRK_FIRST = 8'h80;
  localparam scancode_t SC_BRK_LAST  = 8'hB9;
  localparam scancode_t SC_BRK_LSHIFT = 8'hAA;
  localparam scancode_t SC_BRK_RSHIFT = 8'hB6;
  localparam scancode_t SC_BRK_CTRL   = 8'h9D;

  // Unshifted US layout; zero means no character.
  function automatic ascii_t plain_char(input key_idx_t idx);
    ascii_t c;
    c = 7'h00;
    case (idx)
      6'h02: c = 7'h31;  6'h03: c = 7'h32;  6'h04: c = 7'h33;  6'h05: c = 7'h34;
      6'h06: c = 7'h35;  6'h07: c = 7'h36;  6'h08: c = 7'h37;  6'h09: c = 7'h38;
      6'h0A: c = 7'h39;  6'h0B: c = 7'h30;  6'h0C: c = 7'h2D;  6'h0D: c = 7'h3D;
      6'h10: c = 7'h71;  6'h11: c = 7'h77;  6'h12: c = 7'h65;  6'h13: c = 7'h72;
      6'h14: c = 7'h74;  6'h15: c = 7'h79;  6'h16: c = 7'h75;  6'h17: c = 7'h69;
      6'h18: c = 7'h6F;  6'h19: c = 7'h70;  6'h1A: c = 7'h5B;  6'h1B: c = 7'h5D;
      6'h1C: c = 7'h0A;
      6'h1E: c = 7'h61;  6'h1F: c = 7'h73;  6'h20: c = 7'h64;  6'h21: c = 7'h66;
      6'h22: c = 7'h67;  6'h23: c = 7'h68;  6'h24: c = 7'h6A;  6'h25: c = 7'h6B;
      6'h26: c = 7'h6C;  6'h27: c = 7'h3B;  6'h28: c = 7'h27;  6'h29: c = 7'h60;
      6'h2B: c = 7'h5C;  6'h2C: c = 7'h7A;  6'h2D: c = 7'h78;  6'h2E: c = 7'h63;
      6'h2F: c = 7'h76;  6'h30: c = 7'h62;  6'h31: c = 7'h6E;  6'h32: c = 7'h6D;
      6'h33: c = 7'h2C;  6'h34: c = 7'h2E;  6'h35: c = 7'h2F;
      6'h37: c = 7'h2A;  6'h39: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // Shifted US layout; zero means no character.
  function automatic ascii_t shifted_char(input key_idx_t idx);
    ascii_t c;
    c = 7'h00;
    case (idx)
      6'h02: c = 7'h21;  6'h03: c = 7'h40;  6'h04: c = 7'h23;  6'h05: c = 7'h24;
      6'h06: c = 7'h25;  6'h07: c = 7'h5E;  6'h08: c = 7'h26;  6'h09: c = 7'h2A;
      6'h0A: c = 7'h28;  6'h0B: c = 7'h29;  6'h0C: c = 7'h5F;  6'h0D: c = 7'h2B;
      6'h10: c = 7'h51;  6'h11: c = 7'h57;  6'h12: c = 7'h45;  6'h13: c = 7'h52;
      6'h14: c = 7'h54;  6'h15: c = 7'h59;  6'h16: c = 7'h55;  6'h17: c = 7'h49;
      6'h18: c = 7'h4F;  6'h19: c = 7'h50;  6'h1A: c = 7'h7B;  6'h1B: c = 7'h7D;
      6'h1C: c = 7'h0A;
      6'h1E: c = 7'h41;  6'h1F: c = 7'h53;  6'h20: c = 7'h44;  6'h21: c = 7'h46;
      6'h22: c = 7'h47;  6'h23: c = 7'h48;  6'h24: c = 7'h4A;  6'h25: c = 7'h4B;
      6'h26: c = 7'h4C;  6'h27: c = 7'h3A;  6'h28: c = 7'h22;  6'h29: c = 7'h7E;
      6'h2B: c = 7'h7C;  6'h2C: c = 7'h5A;  6'h2D: c = 7'h58;  6'h2E: c = 7'h43;
      6'h2F: c = 7'h56;  6'h30: c = 7'h42;  6'h31: c = 7'h4E;  6'h32: c = 7'h4D;
      6'h33: c = 7'h3C;  6'h34: c = 7'h3E;  6'h35: c = 7'h3F;
      6'h37: c = 7'h2A;  6'h39: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/scancode_to_ascii_with_modifiers.sv -----
// Set-1 scancode to ASCII translator with shift, ctrl and caps lock tracking.
// Depends on sc2a_pkg (key codes and layout tables).
//
// Usage:
//   Input channel (in_valid / in_stall / in_scancode): one raw set-1 byte per
//   beat; bit 7 set marks a key release. Result channel (out_valid /
//   out_stall / out_*): exactly one result beat per input beat, in order.
//   A byte passes through the input register, then the result register.
//   Throughput: one byte per cycle while the receiver keeps out_stall low;
//   the only logic between the two registers is a lookup in the plain or
//   shifted table (64 entries each) and the modifier update.
//   Stall: the result register holds while out_stall is high; the input
//   register still takes one more byte if it is empty, and then in_stall
//   rises until the result register frees up. Modifier flags change only
//   when a byte moves from the input register into the result register.
//   Reset (rst_n low, synchronous): both stages empty, shift, ctrl and caps
//   lock cleared.
module scancode_to_ascii_with_modifiers
  import sc2a_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  scancode_t in_scancode,
  output logic      out_valid,
  input  logic      out_stall,
  output logic      out_char_valid,
  output ascii_t    out_char_code,
  output logic      out_do_backspace,
  output logic      out_do_clear,
  output logic      out_do_word_delete,
  output logic      out_show_prompt,
  output logic      out_bad_code
);

  // Input stage
  logic      s1_valid_r;
  scancode_t s1_code_r;
  // Modifier flags
  logic      shift_r, caps_r, ctrl_r;
  logic      shift_nxt, caps_nxt, ctrl_nxt;
  // Result stage
  logic      out_valid_r;
  logic      char_valid_r, char_valid_nxt;
  ascii_t    char_code_r, char_code_nxt;
  logic      bksp_r, bksp_nxt;
  logic      clr_r, clr_nxt;
  logic      wdel_r, wdel_nxt;
  logic      prompt_r, prompt_nxt;
  logic      bad_r, bad_nxt;

  logic      out_free;
  logic      s1_move;
  logic      is_make, is_brk;
  ascii_t    lookup;

  // Result register can take a new beat when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  // Input register: load on accept, drop when moved on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_code_r <= in_scancode;
    end
  end

  // Decode: modifiers first, so the ctrl make code itself counts as ctrl held.
  always_comb begin
    is_make = (s1_code_r <= SC_MAKE_LAST);
    is_brk  = (s1_code_r >= SC_BRK_FIRST) && (s1_code_r <= SC_BRK_LAST);

    shift_nxt = shift_r;
    caps_nxt  = caps_r;
    ctrl_nxt  = ctrl_r;
    if (is_make) begin
      if (s1_code_r == SC_LSHIFT || s1_code_r == SC_RSHIFT) shift_nxt = 1'b1;
      if (s1_code_r == SC_CTRL)                             ctrl_nxt  = 1'b1;
      if (s1_code_r == SC_CAPS)                             caps_nxt  = !caps_r;
    end else if (is_brk) begin
      if (s1_code_r == SC_BRK_LSHIFT || s1_code_r == SC_BRK_RSHIFT) shift_nxt = 1'b0;
      if (s1_code_r == SC_BRK_CTRL)                                 ctrl_nxt  = 1'b0;
    end

    lookup = (shift_nxt || caps_nxt) ? shifted_char(s1_code_r[5:0])
                                     : plain_char(s1_code_r[5:0]);

    char_valid_nxt = 1'b0;
    char_code_nxt  = 7'h00;
    bksp_nxt       = 1'b0;
    clr_nxt        = 1'b0;
    wdel_nxt       = 1'b0;
    prompt_nxt     = 1'b0;
    bad_nxt        = 1'b0;
    if (is_make) begin
      bksp_nxt   = (s1_code_r == SC_BACKSPACE);
      prompt_nxt = (s1_code_r == SC_ENTER);
      if (ctrl_nxt) begin
        clr_nxt  = (s1_code_r == SC_L);
        wdel_nxt = (s1_code_r == SC_BACKSPACE);
      end else if (s1_code_r == SC_NULL) begin
        bad_nxt = 1'b1;
      end else if (lookup != 7'h00) begin
        char_valid_nxt = 1'b1;
        char_code_nxt  = lookup;
      end
    end
  end

  // Advance modifier flags and result valid as a beat moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= 1'b0;
      caps_r      <= 1'b0;
      ctrl_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_move) begin
        shift_r <= shift_nxt;
        caps_r  <= caps_nxt;
        ctrl_r  <= ctrl_nxt;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Result payload: hold while stalled.
  always_ff @(posedge clk) begin
    if (s1_move) begin
      char_valid_r <= char_valid_nxt;
      char_code_r  <= char_code_nxt;
      bksp_r       <= bksp_nxt;
      clr_r        <= clr_nxt;
      wdel_r       <= wdel_nxt;
      prompt_r     <= prompt_nxt;
      bad_r        <= bad_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_char_valid     = char_valid_r;
  assign out_char_code      = char_code_r;
  assign out_do_backspace   = bksp_r;
  assign out_do_clear       = clr_r;
  assign out_do_word_delete = wdel_r;
  assign out_show_prompt    = prompt_r;
  assign out_bad_code       = bad_r;

  // Word delete is always a ctrl backspace, so backspace comes with it.
  a_wdel_has_bksp : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!wdel_r || bksp_r))
    else $error("word delete without backspace");

  // Ctrl commands and errors never come with a printable character.
  a_no_char_with_cmd : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(char_valid_r && (clr_r || wdel_r || bad_r)))
    else $error("character reported together with a command or error");

  // No character means a zero code.
  a_code_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !char_valid_r) |-> (char_code_r == 7'h00))
    else $error("character code set without char_valid");

  // Modifier flags change only when a beat moves into the result register.
  a_mods_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !s1_move |=> ($stable(shift_r) && $stable(caps_r) && $stable(ctrl_r)))
    else $error("modifier flags changed without a beat");

  // Input stalls only while the input register is full and blocked.
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

endmodule
